### rtl/positional_list_store_core_macros.svh
// Assertion macros shared by the positional list store RTL.
// Depends on nothing; the asserting module supplies clk_i and rst_ni.
`ifndef POSITIONAL_LIST_STORE_CORE_MACROS_SVH
`define POSITIONAL_LIST_STORE_CORE_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define PLST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on every rising edge, reset included.
`define PLST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

### rtl/plst_pkg.sv
// Package of the positional list store: sizes, codes and the command and
// status records between controller and datapath. Depends on nothing.
`timescale 1ns / 1ps

package plst_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned OP_W     = 2;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned COUNT_W  = 7;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [INDEX_W-1:0]      index_t;
  typedef logic [COUNT_W-1:0]      count_t;

  localparam cnt_t DEPTH_C = cnt_t'(DEPTH);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_INVALID   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CHK,
    S_DEL_WR,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_RD_RD,
    S_RD_EMIT,
    S_RESP
  } state_e;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_COUNT,
    PTR_POS,
    PTR_INC,
    PTR_DEC
  } ptr_sel_e;

  typedef enum logic [1:0] {
    RD_AT,
    RD_BELOW,
    RD_ABOVE
  } rd_sel_e;

  typedef struct packed {
    logic     latch_in;
    ptr_sel_e ptr_sel;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    logic     wr_value;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     st_load;
    status_e  st_code;
    logic     idx_keep;
    logic     out_load;
    logic     out_entry;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic empty;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic ptr_gt_pos;
    logic ptr_next_lt_cnt;
    logic ptr_lt_cnt;
    logic ptr_last;
    logic match;
    logic out_free;
  } sts_t;

endpackage

### rtl/plst_if.sv
// Channel interfaces of the positional list store: request and result.
// Depends on plst_pkg for field widths.
`timescale 1ns / 1ps

interface plst_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [plst_pkg::OP_W-1:0]            operation;
  logic [plst_pkg::POS_W-1:0]           position;
  logic signed [plst_pkg::VAL_W-1:0]    value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink (input valid, input operation, input position, input value,
                output ready);
endinterface

interface plst_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [plst_pkg::STATUS_W-1:0]        status;
  logic [plst_pkg::INDEX_W-1:0]         index;
  logic signed [plst_pkg::VAL_W-1:0]    element;
  logic [plst_pkg::COUNT_W-1:0]         count;
  logic                                 last;

  modport source (output valid, output status, output index, output element,
                  output count, output last, input ready);
  modport sink (input valid, input status, input index, input element,
                input count, input last, output ready);
endinterface

### rtl/plst_dpath.sv
// Datapath of the positional list store: entry memory, count, walk pointer,
// operand registers and the result register. Depends on plst_pkg.
`timescale 1ns / 1ps

module plst_dpath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  plst_pkg::cmd_t                    cmd_i,
  output plst_pkg::sts_t                    sts_o,
  input  logic [plst_pkg::OP_W-1:0]         operation_i,
  input  logic [plst_pkg::POS_W-1:0]        position_i,
  input  logic signed [plst_pkg::VAL_W-1:0] value_i,
  input  logic                              res_ready_i,
  output logic                              res_valid_o,
  output logic [plst_pkg::STATUS_W-1:0]     status_o,
  output logic [plst_pkg::INDEX_W-1:0]      index_o,
  output logic signed [plst_pkg::VAL_W-1:0] element_o,
  output logic [plst_pkg::COUNT_W-1:0]      count_o,
  output logic                              last_o
);

  plst_pkg::val_t mem [plst_pkg::DEPTH];

  logic [plst_pkg::OP_W-1:0] op_q;
  plst_pkg::pos_t            pos_q;
  plst_pkg::val_t            val_q;
  plst_pkg::cnt_t            cnt_q, cnt_d;
  plst_pkg::cnt_t            ptr_q, ptr_d;
  plst_pkg::cnt_t            ptr_inc, ptr_dec;
  plst_pkg::val_t            rdata_q;
  plst_pkg::addr_t           rd_addr;
  plst_pkg::status_e         st_q;
  plst_pkg::cnt_t            ridx_q;
  logic                      res_valid_q, res_valid_d;
  logic [plst_pkg::STATUS_W-1:0] res_status_q;
  plst_pkg::index_t          res_index_q;
  plst_pkg::val_t            res_element_q;
  plst_pkg::count_t          res_count_q;
  logic                      res_last_q;
  logic                      last_entry;

  assign ptr_inc    = plst_pkg::cnt_t'(ptr_q + 1'b1);
  assign ptr_dec    = plst_pkg::cnt_t'(ptr_q - 1'b1);
  assign last_entry = (ptr_inc == cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q  <= operation_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      plst_pkg::RD_BELOW: rd_addr = plst_pkg::addr_t'(ptr_dec);
      plst_pkg::RD_ABOVE: rd_addr = plst_pkg::addr_t'(ptr_inc);
      default:            rd_addr = plst_pkg::addr_t'(ptr_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[plst_pkg::addr_t'(ptr_q)] <= cmd_i.wr_value ? val_q : rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_comb begin
    case (cmd_i.ptr_sel)
      plst_pkg::PTR_ZERO:  ptr_d = '0;
      plst_pkg::PTR_COUNT: ptr_d = cnt_q;
      plst_pkg::PTR_POS:   ptr_d = plst_pkg::cnt_t'(pos_q);
      plst_pkg::PTR_INC:   ptr_d = ptr_inc;
      plst_pkg::PTR_DEC:   ptr_d = ptr_dec;
      default:             ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = plst_pkg::cnt_t'(cnt_q + 1'b1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = plst_pkg::cnt_t'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ptr_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.st_load) begin
      st_q   <= cmd_i.st_code;
      ridx_q <= cmd_i.idx_keep ? ptr_q : '0;
    end
  end

  assign res_valid_d = cmd_i.out_load ? 1'b1 : (res_ready_i ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_count_q <= plst_pkg::count_t'(cnt_q);
      if (cmd_i.out_entry) begin
        res_status_q  <= plst_pkg::ST_OK;
        res_index_q   <= plst_pkg::index_t'(ptr_q);
        res_element_q <= rdata_q;
        res_last_q    <= last_entry;
      end else begin
        res_status_q  <= st_q;
        res_index_q   <= plst_pkg::index_t'(ridx_q);
        res_element_q <= '0;
        res_last_q    <= 1'b1;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign status_o    = res_status_q;
  assign index_o     = res_index_q;
  assign element_o   = res_element_q;
  assign count_o     = res_count_q;
  assign last_o      = res_last_q;

  always_comb begin
    sts_o.op              = plst_pkg::op_e'(op_q);
    sts_o.full            = (cnt_q >= plst_pkg::DEPTH_C);
    sts_o.empty           = (cnt_q == '0);
    sts_o.pos_gt_cnt      = (pos_q > plst_pkg::pos_t'(cnt_q));
    sts_o.pos_ge_cnt      = (pos_q >= plst_pkg::pos_t'(cnt_q));
    sts_o.ptr_gt_pos      = (plst_pkg::pos_t'(ptr_q) > pos_q);
    sts_o.ptr_next_lt_cnt = (ptr_inc < cnt_q);
    sts_o.ptr_lt_cnt      = (ptr_q < cnt_q);
    sts_o.ptr_last        = last_entry;
    sts_o.match           = (rdata_q == val_q);
    sts_o.out_free        = !res_valid_q || res_ready_i;
  end

endmodule

### rtl/plst_ctrl.sv
// Controller of the positional list store: sequences the shift, search and
// read-out walks over the datapath. Depends on plst_pkg and the macro header.
`timescale 1ns / 1ps
`include "positional_list_store_core_macros.svh"

module plst_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  plst_pkg::sts_t sts_i,
  output plst_pkg::cmd_t cmd_o
);

  plst_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= plst_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    req_ready_o      = 1'b0;
    cmd_o.latch_in   = 1'b0;
    cmd_o.ptr_sel    = plst_pkg::PTR_HOLD;
    cmd_o.rd_en      = 1'b0;
    cmd_o.rd_sel     = plst_pkg::RD_AT;
    cmd_o.wr_en      = 1'b0;
    cmd_o.wr_value   = 1'b0;
    cmd_o.cnt_inc    = 1'b0;
    cmd_o.cnt_dec    = 1'b0;
    cmd_o.st_load    = 1'b0;
    cmd_o.st_code    = plst_pkg::ST_OK;
    cmd_o.idx_keep   = 1'b0;
    cmd_o.out_load   = 1'b0;
    cmd_o.out_entry  = 1'b0;

    case (state_q)
      plst_pkg::S_IDLE: begin
        req_ready_o    = 1'b1;
        cmd_o.latch_in = req_valid_i;
        if (req_valid_i) begin
          state_d = plst_pkg::S_DECIDE;
        end
      end
      plst_pkg::S_DECIDE: begin
        case (sts_i.op)
          plst_pkg::OP_INSERT: begin
            if (sts_i.full) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_code = plst_pkg::ST_FULL;
              state_d       = plst_pkg::S_RESP;
            end else if (sts_i.pos_gt_cnt) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_code = plst_pkg::ST_INVALID;
              state_d       = plst_pkg::S_RESP;
            end else begin
              cmd_o.ptr_sel = plst_pkg::PTR_COUNT;
              state_d       = plst_pkg::S_INS_CHK;
            end
          end
          plst_pkg::OP_DELETE: begin
            if (sts_i.empty) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_code = plst_pkg::ST_EMPTY;
              state_d       = plst_pkg::S_RESP;
            end else if (sts_i.pos_ge_cnt) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_code = plst_pkg::ST_INVALID;
              state_d       = plst_pkg::S_RESP;
            end else begin
              cmd_o.ptr_sel = plst_pkg::PTR_POS;
              state_d       = plst_pkg::S_DEL_CHK;
            end
          end
          plst_pkg::OP_SEARCH: begin
            cmd_o.ptr_sel = plst_pkg::PTR_ZERO;
            state_d       = plst_pkg::S_SRCH_CHK;
          end
          default: begin
            if (sts_i.empty) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st_code = plst_pkg::ST_EMPTY;
              state_d       = plst_pkg::S_RESP;
            end else begin
              cmd_o.ptr_sel = plst_pkg::PTR_ZERO;
              state_d       = plst_pkg::S_RD_RD;
            end
          end
        endcase
      end
      plst_pkg::S_INS_CHK: begin
        if (sts_i.ptr_gt_pos) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = plst_pkg::RD_BELOW;
          state_d      = plst_pkg::S_INS_WR;
        end else begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_value = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          cmd_o.st_load  = 1'b1;
          state_d        = plst_pkg::S_RESP;
        end
      end
      plst_pkg::S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.ptr_sel = plst_pkg::PTR_DEC;
        state_d       = plst_pkg::S_INS_CHK;
      end
      plst_pkg::S_DEL_CHK: begin
        if (sts_i.ptr_next_lt_cnt) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = plst_pkg::RD_ABOVE;
          state_d      = plst_pkg::S_DEL_WR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          cmd_o.st_load = 1'b1;
          state_d       = plst_pkg::S_RESP;
        end
      end
      plst_pkg::S_DEL_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.ptr_sel = plst_pkg::PTR_INC;
        state_d       = plst_pkg::S_DEL_CHK;
      end
      plst_pkg::S_SRCH_CHK: begin
        if (sts_i.ptr_lt_cnt) begin
          cmd_o.rd_en = 1'b1;
          state_d     = plst_pkg::S_SRCH_CMP;
        end else begin
          cmd_o.st_load = 1'b1;
          cmd_o.st_code = plst_pkg::ST_NOT_FOUND;
          state_d       = plst_pkg::S_RESP;
        end
      end
      plst_pkg::S_SRCH_CMP: begin
        if (sts_i.match) begin
          cmd_o.st_load  = 1'b1;
          cmd_o.idx_keep = 1'b1;
          state_d        = plst_pkg::S_RESP;
        end else begin
          cmd_o.ptr_sel = plst_pkg::PTR_INC;
          state_d       = plst_pkg::S_SRCH_CHK;
        end
      end
      plst_pkg::S_RD_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = plst_pkg::S_RD_EMIT;
      end
      plst_pkg::S_RD_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_entry = 1'b1;
          if (sts_i.ptr_last) begin
            state_d = plst_pkg::S_IDLE;
          end else begin
            cmd_o.ptr_sel = plst_pkg::PTR_INC;
            state_d       = plst_pkg::S_RD_RD;
          end
        end
      end
      plst_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = plst_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = plst_pkg::S_IDLE;
      end
    endcase
  end

  `PLST_ASSERT(a_load_needs_free_slot, cmd_o.out_load |-> sts_i.out_free,
               "result register loaded while still occupied")
  `PLST_ASSERT(a_no_insert_when_full, cmd_o.cnt_inc |-> !sts_i.full,
               "count raised on a full list")
  `PLST_ASSERT(a_no_delete_when_empty, cmd_o.cnt_dec |-> !sts_i.empty,
               "count lowered on an empty list")
  `PLST_ASSERT(a_last_entry_ends_walk,
               (cmd_o.out_entry && sts_i.ptr_last && cmd_o.out_load)
               |=> (state_q == plst_pkg::S_IDLE),
               "read-out did not end after the last entry")
  `PLST_ASSERT_ALWAYS(a_ready_only_idle,
                      req_ready_o |-> (state_q == plst_pkg::S_IDLE),
                      "request taken outside the idle state")

endmodule

### rtl/positional_list_store_core.sv
// Top level of the positional list store: joins the controller and the
// datapath. Depends on plst_pkg, plst_if, plst_ctrl and plst_dpath.
//
// The block keeps an ordered list of up to 64 signed 32-bit entries.
// Requests arrive on req_i (operation, position, value) and results leave on
// res_o (status, index, element, count, last); each is a valid/ready channel
// and a transfer happens at a rising edge with valid and ready both high.
// Insert, delete and search give one result; read-out gives one result per
// entry with last set on the final one, or a single empty status.
// One request is worked on at a time. Insert and delete shift the entries
// between the position and the end, one read and one write per step;
// search reads one entry per step from the front, and read-out reads and
// emits one entry per step. A finished result sits in the result register,
// so the next request is taken while it waits. When the receiver stalls,
// walks that emit results wait with the pointer held. Reset clears the
// count, so the list starts empty; no clearing pass.
`timescale 1ns / 1ps

module positional_list_store_core (
  input logic        clk_i,
  input logic        rst_ni,
  plst_req_if.sink   req_i,
  plst_res_if.source res_o
);

  plst_pkg::cmd_t cmd;
  plst_pkg::sts_t sts;

  plst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  plst_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .operation_i (req_i.operation),
    .position_i  (req_i.position),
    .value_i     (req_i.value),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .status_o    (res_o.status),
    .index_o     (res_o.index),
    .element_o   (res_o.element),
    .count_o     (res_o.count),
    .last_o      (res_o.last)
  );

endmodule
